// ===== hw/rtl/fsa_pkg.sv =====
// Shared types and constants for the fraction sum accumulator.
// Used by every module of the block; depends on nothing.
package fsa_pkg;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam int unsigned RADIX = 10;

	// Term operand field width in the command queue (largest operand size)
	localparam int unsigned TERM_W = 32;

	// Command queue depth
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_ZERO_DEN = 2'd2,
		ST_BAD_CHAR = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} char_word_t;

	typedef struct packed {
		logic signed [63:0] numerator;
		logic [62:0]        denominator;
		status_t            status;
	} sum_word_t;

	// One classified character: error before the close, term close, error after, emit
	typedef struct packed {
		status_t           pre_err;
		logic              do_close;
		logic              neg;
		logic [TERM_W-1:0] num;
		logic [TERM_W-1:0] den;
		status_t           post_err;
		logic              emit;
	} cmd_t;

	typedef enum logic [2:0] {
		ALU_GCD = 3'b001,
		ALU_DIV = 3'b010,
		ALU_MUL = 3'b100
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic busy;
	} alu_rsp_t;

endpackage

// ===== hw/rtl/fsa_front.sv =====
// Front end: accepts characters, parses digits and signs, emits commands.
// Depends on fsa_pkg.
module fsa_front #(
	parameter int unsigned OPERAND_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  fsa_pkg::char_word_t char_word,
	output logic                cmd_push,
	output fsa_pkg::cmd_t       cmd_word,
	input  logic                cmd_full
);

	localparam int unsigned VW = OPERAND_BITS + 4;

	logic [OPERAND_BITS-1:0] acc_q, term_q;
	logic                    neg_q, in_den_q, at_start_q;

	logic [OPERAND_BITS-1:0] acc_n, term_n;
	logic                    neg_n, in_den_n;
	logic [VW-1:0]           v;
	logic                    is_digit, is_sign, is_minus;
	fsa_pkg::status_t        pre_err, post_err;
	logic                    do_close, emit;
	logic [OPERAND_BITS-1:0] close_num, close_den;
	logic                    close_neg;
	logic                    accept;

	assign char_ready = !cmd_full;
	assign accept     = char_valid && char_ready;

	assign is_digit = (char_word.chr >= fsa_pkg::CH_ZERO) && (char_word.chr <= fsa_pkg::CH_NINE);
	assign is_minus = (char_word.chr == fsa_pkg::CH_MINUS);
	assign is_sign  = is_minus || (char_word.chr == fsa_pkg::CH_PLUS);
	assign v = VW'(acc_q) * VW'(fsa_pkg::RADIX) + VW'(char_word.chr - fsa_pkg::CH_ZERO);

	// Classify the character and work out the next parse state
	always_comb begin
		acc_n     = acc_q;
		term_n    = term_q;
		neg_n     = neg_q;
		in_den_n  = in_den_q;
		pre_err   = fsa_pkg::ST_OK;
		post_err  = fsa_pkg::ST_OK;
		do_close  = 1'b0;
		close_num = term_q;
		close_den = acc_q;
		close_neg = neg_q;
		emit      = 1'b0;
		if (is_digit) begin
			if (|v[VW-1:OPERAND_BITS]) begin
				pre_err = fsa_pkg::ST_OVERFLOW;
				acc_n   = '1;
			end else begin
				acc_n = v[OPERAND_BITS-1:0];
			end
		end else if (char_word.chr == fsa_pkg::CH_SLASH) begin
			if (in_den_q) begin
				pre_err = fsa_pkg::ST_BAD_CHAR;
			end else begin
				term_n   = acc_q;
				acc_n    = '0;
				in_den_n = 1'b1;
			end
		end else if (is_sign) begin
			if (at_start_q) begin
				neg_n = is_minus;
			end else if (in_den_q) begin
				do_close = 1'b1;
				neg_n    = is_minus;
				in_den_n = 1'b0;
				acc_n    = '0;
				term_n   = '0;
			end else begin
				pre_err = fsa_pkg::ST_BAD_CHAR;
			end
		end else begin
			pre_err = fsa_pkg::ST_BAD_CHAR;
		end
		// Close the open term on the final character, or flag a bad character if no denominator is open
		if (char_word.last) begin
			emit = 1'b1;
			if (in_den_n) begin
				do_close  = 1'b1;
				close_num = term_n;
				close_den = acc_n;
				close_neg = neg_n;
			end else begin
				post_err = fsa_pkg::ST_BAD_CHAR;
			end
		end
	end

	assign cmd_push = accept && ((pre_err != fsa_pkg::ST_OK) || do_close || emit);
	assign cmd_word = '{pre_err:  pre_err,
	                    do_close: do_close,
	                    neg:      close_neg,
	                    num:      fsa_pkg::TERM_W'(close_num),
	                    den:      fsa_pkg::TERM_W'(close_den),
	                    post_err: post_err,
	                    emit:     emit};

	// Advance the parse state; drop it back to start after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			term_q     <= '0;
			neg_q      <= 1'b0;
			in_den_q   <= 1'b0;
			at_start_q <= 1'b1;
		end else if (accept) begin
			if (char_word.last) begin
				acc_q      <= '0;
				term_q     <= '0;
				neg_q      <= 1'b0;
				in_den_q   <= 1'b0;
				at_start_q <= 1'b1;
			end else begin
				acc_q      <= acc_n;
				term_q     <= term_n;
				neg_q      <= neg_n;
				in_den_q   <= in_den_n;
				at_start_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/fsa_queue.sv =====
// Short command queue between the parser and the arithmetic back end.
// Depends on fsa_pkg.
module fsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fsa_pkg::cmd_t push_word,
	output logic          full,
	input  logic          pop,
	output fsa_pkg::cmd_t pop_word,
	output logic          empty
);

	fsa_pkg::cmd_t                mem [fsa_pkg::Q_DEPTH];
	logic [fsa_pkg::Q_PTR_W-1:0]  wr_q, rd_q;
	logic [fsa_pkg::Q_PTR_W:0]    cnt_q;

	assign full     = (cnt_q == (fsa_pkg::Q_PTR_W+1)'(fsa_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_word = mem[rd_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_q] <= push_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/fsa_alu.sv =====
// Shared serial arithmetic unit: binary gcd, restoring divide and
// saturation-checked shift-add multiply, one step per cycle. Depends on fsa_pkg.
module fsa_alu #(
	parameter int unsigned DW       = 64,
	parameter int unsigned ACC_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fsa_pkg::alu_req_t req,
	input  logic [DW-1:0]     a,
	input  logic [DW-1:0]     b,
	output fsa_pkg::alu_rsp_t rsp,
	output logic [DW-1:0]     res
);

	localparam int unsigned CW = $clog2(DW + 1);
	localparam logic [DW:0] LIM = (DW+1)'((65'd1 << (ACC_BITS - 1)) - 65'd1);

	logic              busy_q, done_q, ovf_q;
	fsa_pkg::alu_op_t  op_q;
	logic [DW-1:0]     x_q, y_q;
	logic [DW:0]       acc_q;
	logic [CW-1:0]     cnt_q, k_q;

	logic [DW:0]       mul_sum, div_r;
	logic              div_ge;

	assign mul_sum = {acc_q[DW-1:0], 1'b0} + (y_q[DW-1] ? {1'b0, x_q} : '0);
	assign div_r   = {acc_q[DW-1:0], x_q[DW-1]};
	assign div_ge  = (div_r >= {1'b0, y_q});

	assign rsp = '{done: done_q, ovf: ovf_q, busy: busy_q};
	assign res = (op_q == fsa_pkg::ALU_MUL) ? acc_q[DW-1:0] : x_q;

	// Run one step of the selected operation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			op_q   <= fsa_pkg::ALU_GCD;
			cnt_q  <= '0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					ovf_q  <= 1'b0;
					cnt_q  <= '0;
					k_q    <= '0;
				end
			end else begin
				unique case (op_q)
					fsa_pkg::ALU_MUL, fsa_pkg::ALU_DIV: begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(DW - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
						if (op_q == fsa_pkg::ALU_MUL && !ovf_q && mul_sum > LIM) begin
							ovf_q <= 1'b1;
						end
					end
					fsa_pkg::ALU_GCD: begin
						if (x_q == y_q) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else if (!x_q[0] && !y_q[0]) begin
							k_q <= k_q + 1'b1;
						end
					end
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				x_q   <= a;
				y_q   <= b;
				acc_q <= '0;
			end
		end else begin
			case (op_q)
				fsa_pkg::ALU_MUL: begin
					if (!ovf_q && mul_sum <= LIM) begin
						acc_q <= mul_sum;
					end
					y_q <= {y_q[DW-2:0], 1'b0};
				end
				fsa_pkg::ALU_DIV: begin
					acc_q <= div_ge ? (div_r - {1'b0, y_q}) : div_r;
					x_q   <= {x_q[DW-2:0], div_ge};
				end
				default: begin
					if (x_q == y_q) begin
						x_q <= x_q << k_q;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= (x_q - y_q) >> 1;
					end else begin
						y_q <= (y_q - x_q) >> 1;
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/fsa_back.sv =====
// Back end: executes queued commands on the running sum with the serial
// arithmetic unit and holds the result register. Depends on fsa_pkg.
module fsa_back #(
	parameter int unsigned DW       = 64,
	parameter int unsigned ACC_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fsa_pkg::cmd_t      cmd_word,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	output logic               sum_valid,
	input  logic               sum_ready,
	output fsa_pkg::sum_word_t sum_word,
	output fsa_pkg::alu_req_t  alu_req,
	output logic [DW-1:0]      alu_a,
	output logic [DW-1:0]      alu_b,
	input  fsa_pkg::alu_rsp_t  alu_rsp,
	input  logic [DW-1:0]      alu_res
);

	localparam logic [DW:0] LIM = (DW+1)'((65'd1 << (ACC_BITS - 1)) - 65'd1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_GCD1 = 12'b000000000010,
		S_DIVB = 12'b000000000100,
		S_DIVA = 12'b000000001000,
		S_MULL = 12'b000000010000,
		S_MULA = 12'b000000100000,
		S_MULB = 12'b000001000000,
		S_ADD  = 12'b000010000000,
		S_GCD2 = 12'b000100000000,
		S_DIVN = 12'b001000000000,
		S_DIVD = 12'b010000000000,
		S_FIN  = 12'b100000000000
	} state_t;

	state_t             st_q;
	fsa_pkg::cmd_t      ent_q;
	fsa_pkg::status_t   err_q;
	logic               issued_q;
	logic               neg_q, tneg_q;
	logic [DW-1:0]      mag_q, den_q, g_q, fa_q, fb_q, l_q, xa_q, xb_q, tmag_q;
	logic               out_valid_q;
	fsa_pkg::sum_word_t out_q;

	logic [DW-1:0]      tnum, tden;
	fsa_pkg::status_t   err_in, err_fin;
	logic [DW:0]        add_sum;
	logic [DW-1:0]      add_mag;
	logic               add_neg, add_ovf;

	assign tnum = DW'(ent_q.num);
	assign tden = DW'(ent_q.den);

	assign cmd_pop   = (st_q == S_IDLE) && !cmd_empty;
	assign sum_valid = out_valid_q;
	assign sum_word  = out_q;

	assign err_in  = (err_q != fsa_pkg::ST_OK) ? err_q : cmd_word.pre_err;
	assign err_fin = (err_q != fsa_pkg::ST_OK) ? err_q : ent_q.post_err;

	// Select operands for the arithmetic unit
	always_comb begin
		alu_a       = den_q;
		alu_b       = tden;
		alu_req.op  = fsa_pkg::ALU_GCD;
		unique case (st_q)
			S_GCD1: begin alu_a = den_q;  alu_b = tden; alu_req.op = fsa_pkg::ALU_GCD; end
			S_DIVB: begin alu_a = den_q;  alu_b = g_q;  alu_req.op = fsa_pkg::ALU_DIV; end
			S_DIVA: begin alu_a = tden;   alu_b = g_q;  alu_req.op = fsa_pkg::ALU_DIV; end
			S_MULL: begin alu_a = fb_q;   alu_b = tden; alu_req.op = fsa_pkg::ALU_MUL; end
			S_MULA: begin alu_a = mag_q;  alu_b = fa_q; alu_req.op = fsa_pkg::ALU_MUL; end
			S_MULB: begin alu_a = tnum;   alu_b = fb_q; alu_req.op = fsa_pkg::ALU_MUL; end
			S_GCD2: begin alu_a = tmag_q; alu_b = l_q;  alu_req.op = fsa_pkg::ALU_GCD; end
			S_DIVN: begin alu_a = tmag_q; alu_b = g_q;  alu_req.op = fsa_pkg::ALU_DIV; end
			S_DIVD: begin alu_a = l_q;    alu_b = g_q;  alu_req.op = fsa_pkg::ALU_DIV; end
			default: begin alu_a = den_q; alu_b = tden; alu_req.op = fsa_pkg::ALU_GCD; end
		endcase
		alu_req.start = !issued_q && !alu_rsp.busy && !(st_q == S_IDLE || st_q == S_ADD
			|| st_q == S_FIN);
	end

	// Add or subtract the scaled magnitudes
	always_comb begin
		add_sum = {1'b0, xa_q} + {1'b0, xb_q};
		add_ovf = 1'b0;
		if (neg_q == ent_q.neg) begin
			add_mag = add_sum[DW-1:0];
			add_neg = neg_q;
			add_ovf = (add_sum > LIM);
		end else if (xa_q >= xb_q) begin
			add_mag = xa_q - xb_q;
			add_neg = neg_q;
		end else begin
			add_mag = xb_q - xa_q;
			add_neg = ent_q.neg;
		end
	end

	// Sequence the term close and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			err_q       <= fsa_pkg::ST_OK;
			issued_q    <= 1'b0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			den_q       <= DW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && sum_ready) begin
				out_valid_q <= 1'b0;
			end
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end
			if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						err_q <= err_in;
						if (cmd_word.do_close && err_in == fsa_pkg::ST_OK) begin
							if (cmd_word.den == '0) begin
								err_q <= fsa_pkg::ST_ZERO_DEN;
								st_q  <= S_FIN;
							end else begin
								st_q <= S_GCD1;
							end
						end else begin
							st_q <= S_FIN;
						end
					end
				end
				S_GCD1: if (alu_rsp.done) st_q <= S_DIVB;
				S_DIVB: if (alu_rsp.done) st_q <= S_DIVA;
				S_DIVA: if (alu_rsp.done) st_q <= S_MULL;
				S_MULL: begin
					if (alu_rsp.done) begin
						if (alu_rsp.ovf) begin
							err_q <= fsa_pkg::ST_OVERFLOW;
							st_q  <= S_FIN;
						end else begin
							st_q <= S_MULA;
						end
					end
				end
				S_MULA: begin
					if (alu_rsp.done) begin
						if (alu_rsp.ovf) begin
							err_q <= fsa_pkg::ST_OVERFLOW;
							st_q  <= S_FIN;
						end else begin
							st_q <= S_MULB;
						end
					end
				end
				S_MULB: begin
					if (alu_rsp.done) begin
						if (alu_rsp.ovf) begin
							err_q <= fsa_pkg::ST_OVERFLOW;
							st_q  <= S_FIN;
						end else begin
							st_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					if (add_ovf) begin
						err_q <= fsa_pkg::ST_OVERFLOW;
						st_q  <= S_FIN;
					end else if (add_mag == '0) begin
						mag_q <= '0;
						neg_q <= 1'b0;
						den_q <= DW'(1);
						st_q  <= S_FIN;
					end else begin
						st_q <= S_GCD2;
					end
				end
				S_GCD2: if (alu_rsp.done) st_q <= S_DIVN;
				S_DIVN: begin
					if (alu_rsp.done) begin
						mag_q <= alu_res;
						neg_q <= tneg_q;
						st_q  <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (alu_rsp.done) begin
						den_q <= alu_res;
						st_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ent_q.emit) begin
						err_q <= err_fin;
						st_q  <= S_IDLE;
					end else if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						err_q       <= fsa_pkg::ST_OK;
						mag_q       <= '0;
						neg_q       <= 1'b0;
						den_q       <= DW'(1);
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Capture operands and intermediate values
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ent_q <= cmd_word;
		end
		if (alu_rsp.done) begin
			case (st_q)
				S_GCD1, S_GCD2: g_q  <= alu_res;
				S_DIVB:         fb_q <= alu_res;
				S_DIVA:         fa_q <= alu_res;
				S_MULL:         l_q  <= alu_res;
				S_MULA:         xa_q <= alu_res;
				S_MULB:         xb_q <= alu_res;
				default:        g_q  <= g_q;
			endcase
		end
		if (st_q == S_ADD) begin
			tmag_q <= add_mag;
			tneg_q <= add_neg;
		end
		if (st_q == S_FIN && ent_q.emit && !out_valid_q) begin
			out_q.status <= err_fin;
			if (err_fin != fsa_pkg::ST_OK) begin
				out_q.numerator   <= '0;
				out_q.denominator <= 63'd1;
			end else begin
				out_q.numerator   <= neg_q ? -$signed(64'(mag_q)) : $signed(64'(mag_q));
				out_q.denominator <= 63'(den_q);
			end
		end
	end

endmodule

// ===== hw/rtl/fraction_sum_text_accumulator_top.sv =====
// Top level of the fraction sum accumulator: parser, command queue,
// arithmetic back end and serial arithmetic unit. Depends on fsa_pkg.
//
//   channel | direction | word          | handshake
//   char    | in        | chr, last     | char_valid / char_ready
//   sum     | out       | num, den, st  | sum_valid / sum_ready
//
// A digit, '/' or leading sign is taken by the parser whenever the queue is not full.
// A term close runs in the back end on one shared serial unit: two gcds of
// up to about 2*DW steps, and four divides and three multiplies of DW steps each;
// a four-entry queue lets the parser keep taking characters meanwhile, and the
// parser stalls only when the queue is full. The result waits in its own register.
// Reset clears all parse, sum and handshake state at once.
module fraction_sum_text_accumulator_top #(
	parameter int unsigned OPERAND_BITS = 32,
	parameter int unsigned ACC_BITS     = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  fsa_pkg::char_word_t char_word,
	output logic               sum_valid,
	input  logic               sum_ready,
	output fsa_pkg::sum_word_t sum_word
);

	localparam int unsigned DW = (ACC_BITS > OPERAND_BITS) ? ACC_BITS : OPERAND_BITS;

	fsa_pkg::cmd_t     push_word, pop_word;
	logic              push, full, pop, empty;
	fsa_pkg::alu_req_t alu_req;
	fsa_pkg::alu_rsp_t alu_rsp;
	logic [DW-1:0]     alu_a, alu_b, alu_res;

	fsa_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word),
		.cmd_push   (push),
		.cmd_word   (push_word),
		.cmd_full   (full)
	);

	fsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	fsa_back #(.DW(DW), .ACC_BITS(ACC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (pop_word),
		.cmd_empty (empty),
		.cmd_pop   (pop),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum_word  (sum_word),
		.alu_req   (alu_req),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_rsp   (alu_rsp),
		.alu_res   (alu_res)
	);

	fsa_alu #(.DW(DW), .ACC_BITS(ACC_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

endmodule

// ===== hw/rtl/fsa_checker.sv =====
// Port-level checks for the fraction sum accumulator, bound to the top level.
// Depends on fsa_pkg.
module fsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_ready,
	input fsa_pkg::char_word_t char_word,
	input logic               sum_valid,
	input logic               sum_ready,
	input fsa_pkg::sum_word_t sum_word
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_ready |=> sum_valid && $stable(sum_word))
		else $error("result word changed while stalled");

	// Error results carry 0/1
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_word.status != fsa_pkg::ST_OK |->
		sum_word.numerator == '0 && sum_word.denominator == 63'd1)
		else $error("error result not 0/1");

	// Denominator never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> sum_word.denominator != '0)
		else $error("zero denominator on output");

	// Zero sum is reduced to 0/1
	a_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_word.numerator == '0 |-> sum_word.denominator == 63'd1)
		else $error("zero sum not reduced");

endmodule

bind fraction_sum_text_accumulator_top fsa_checker u_fsa_checker (.*);
